@@ hw/rtl/kabf_pkg.sv @@
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared constants, codes and controller/datapath interface types of the
// two-state angle and gyro bias Kalman filter.
// ----------------------------------------------------------------------------
package kabf_pkg;

	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS      = 24;
	localparam int DIGIT_BITS     = 16;

	localparam int ANGLE_W  = 25;
	localparam int RATE_W   = 28;
	localparam int DT_W     = 25;
	localparam int OUT_W    = 32;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 2;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 96;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
	localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd503316;

	typedef enum logic [3:0] {
		MOP_ANGLE_PRED,
		MOP_T,
		MOP_P0_PRED,
		MOP_P3_PRED,
		MOP_ANGLE_CORR,
		MOP_BIAS_CORR,
		MOP_P0_CORR,
		MOP_P1_CORR,
		MOP_P2_CORR,
		MOP_P3_CORR
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MUL_WAIT,
		ST_INNER,
		ST_GAIN,
		ST_DIV,
		ST_DIV_WAIT,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		logic    mul_wb;
		mul_op_t mul_op;
		logic    step_inner;
		logic    step_gain;
		logic    div_start;
		logic    div_wb;
		logic    out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic mul_busy;
		logic mul_done;
		logic div_busy;
		logic div_done;
	} dp_status_t;

endpackage

@@ hw/rtl/kabf_mul.sv @@
// ----------------------------------------------------------------------------
// kabf_mul
// Sequential fractional multiplier: magnitude product built one 16-bit digit
// per cycle, then rounded half away from zero and saturated to the word.
// ----------------------------------------------------------------------------
module kabf_mul #(
	parameter int W = kabf_pkg::WORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic                busy,
	output logic                done,
	output logic signed [W-1:0] res
);
	import kabf_pkg::*;

	localparam int CH = (W + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int BW = CH * DIGIT_BITS;
	localparam int AW = BW + W;
	localparam int MW = AW - FRAC_BITS + 1;
	localparam int CW = $clog2(CH + 1);
	localparam logic [AW:0] RND_HALF =
		{{(AW - FRAC_BITS + 1){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
	localparam logic [MW-1:0] LIM_POS = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic [MW-1:0] LIM_NEG = {{(MW - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

	logic [W-1:0]            ua_q;
	logic [BW-1:0]           ub_q;
	logic [AW-1:0]           acc_q;
	logic                    neg_q;
	logic [CW-1:0]           cnt_q;
	logic                    busy_q;
	logic                    fin_q;
	logic                    done_q;
	logic signed [W-1:0]     res_q;
	logic [W+DIGIT_BITS-1:0] part;
	logic [AW:0]             rnd;
	logic [MW-1:0]           mag;
	logic [MW-1:0]           lim;
	logic [MW-1:0]           sel;
	logic [W-1:0]            mag_w;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? ((~v) + W'(1)) : v;
	endfunction

	assign part  = (W + DIGIT_BITS)'(ua_q) * (W + DIGIT_BITS)'(ub_q[BW-1 -: DIGIT_BITS]);
	assign rnd   = {1'b0, acc_q} + RND_HALF;
	assign mag   = rnd[AW:FRAC_BITS];
	assign lim   = neg_q ? LIM_NEG : LIM_POS;
	assign sel   = (mag > lim) ? lim : mag;
	assign mag_w = sel[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(CH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= mag_of(a);
			ub_q  <= BW'(mag_of(b));
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[AW-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}} + AW'(part);
			ub_q  <= ub_q << DIGIT_BITS;
		end
		if (fin_q) begin
			res_q <= neg_q ? -mag_w : mag_w;
		end
	end

	assign busy = busy_q | fin_q;
	assign done = done_q;
	assign res  = res_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !fin_q)
		else $error("multiplier started while busy");
`endif

endmodule

@@ hw/rtl/kabf_div.sv @@
// ----------------------------------------------------------------------------
// kabf_div
// Restoring fractional divider, one quotient bit per cycle, dividing two
// numerators by one shared divisor; truncates and saturates to the word.
// ----------------------------------------------------------------------------
module kabf_div #(
	parameter int W = kabf_pkg::WORD_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [W-1:0] n0,
	input  logic signed [W-1:0] n1,
	input  logic signed [W-1:0] d,
	output logic                busy,
	output logic                done,
	output logic signed [W-1:0] q0,
	output logic signed [W-1:0] q1
);
	import kabf_pkg::*;

	localparam int N  = W + FRAC_BITS;
	localparam int CW = $clog2(N + 1);
	localparam logic [N-1:0] LIM_POS = {{(N - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic [N-1:0] LIM_NEG = {{(N - W){1'b0}}, 1'b1, {(W - 1){1'b0}}};

	logic [N-1:0]        dv0_q;
	logic [N-1:0]        dv1_q;
	logic [W-1:0]        rem0_q;
	logic [W-1:0]        rem1_q;
	logic [W-1:0]        ud_q;
	logic                neg0_q;
	logic                neg1_q;
	logic                zero_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	logic signed [W-1:0] q0_q;
	logic signed [W-1:0] q1_q;
	logic [W:0]          st0;
	logic [W:0]          st1;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? ((~v) + W'(1)) : v;
	endfunction

	// returns {quotient bit, new remainder}
	function automatic logic [W:0] div_step(input logic [W-1:0] rem, input logic bit_in,
		input logic [W-1:0] ud);
		logic [W:0] trial;
		logic [W:0] diff;
		trial = {rem, bit_in};
		diff  = trial - {1'b0, ud};
		return diff[W] ? {1'b0, trial[W-1:0]} : {1'b1, diff[W-1:0]};
	endfunction

	function automatic logic [W-1:0] sat_quot(input logic [N-1:0] q, input logic neg,
		input logic zero);
		logic [N-1:0] lim;
		logic [W-1:0] m;
		lim = neg ? LIM_NEG : LIM_POS;
		m   = (q > lim) ? lim[W-1:0] : q[W-1:0];
		return zero ? '0 : (neg ? -m : m);
	endfunction

	assign st0 = div_step(rem0_q, dv0_q[N-1], ud_q);
	assign st1 = div_step(rem1_q, dv1_q[N-1], ud_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dv0_q  <= {mag_of(n0), {FRAC_BITS{1'b0}}};
			dv1_q  <= {mag_of(n1), {FRAC_BITS{1'b0}}};
			rem0_q <= '0;
			rem1_q <= '0;
			ud_q   <= mag_of(d);
			neg0_q <= n0[W-1] ^ d[W-1];
			neg1_q <= n1[W-1] ^ d[W-1];
			zero_q <= (d == '0);
		end else if (busy_q) begin
			dv0_q  <= {dv0_q[N-2:0], st0[W]};
			dv1_q  <= {dv1_q[N-2:0], st1[W]};
			rem0_q <= st0[W-1:0];
			rem1_q <= st1[W-1:0];
		end
		if (fin_q) begin
			q0_q <= sat_quot(dv0_q, neg0_q, zero_q);
			q1_q <= sat_quot(dv1_q, neg1_q, zero_q);
		end
	end

	assign busy = busy_q | fin_q;
	assign done = done_q;
	assign q0   = q0_q;
	assign q1   = q1_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q && !fin_q && !done_q)
		else $error("divider started while busy");
`endif

endmodule

@@ hw/rtl/kabf_datapath.sv @@
// ----------------------------------------------------------------------------
// kabf_datapath
// Filter state, noise registers, saturating adders, the shared multiplier
// and divider, and the output word register.
// ----------------------------------------------------------------------------
module kabf_datapath #(
	parameter int W = kabf_pkg::WORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kabf_pkg::ctrl_cmd_t                 cmd,
	output kabf_pkg::dp_status_t                status,
	input  logic signed [kabf_pkg::ANGLE_W-1:0] measured_angle,
	input  logic signed [kabf_pkg::RATE_W-1:0]  measured_rate,
	input  logic [kabf_pkg::DT_W-1:0]           time_step,
	input  logic                                cfg_we,
	input  logic [kabf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kabf_pkg::CFG_W-1:0]          cfg_wdata,
	output logic signed [kabf_pkg::OUT_W-1:0]   filtered_angle,
	output logic signed [kabf_pkg::OUT_W-1:0]   unbiased_rate,
	output logic signed [kabf_pkg::OUT_W-1:0]   bias_estimate
);
	import kabf_pkg::*;

	localparam int EW = W + 2;
	localparam int XI = ((W > 32) ? W : 32) + 1;
	localparam logic signed [EW-1:0] WMAX_E = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [EW-1:0] WMIN_E = {{(EW - W + 1){1'b1}}, {(W - 1){1'b0}}};
	localparam logic signed [XI-1:0] WMAX_X = {{(XI - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [XI-1:0] WMIN_X = {{(XI - W + 1){1'b1}}, {(W - 1){1'b0}}};
	localparam logic signed [XI-1:0] OMAX_X = {{(XI - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [XI-1:0] OMIN_X = {{(XI - 31){1'b1}}, {31{1'b0}}};

	logic [CFG_W-1:0]    qa_q;
	logic [CFG_W-1:0]    qb_q;
	logic [CFG_W-1:0]    rm_q;
	logic signed [W-1:0] ang_q;
	logic signed [W-1:0] bias_q;
	logic signed [W-1:0] p_q [4];
	logic signed [W-1:0] ma_q;
	logic signed [W-1:0] dt_q;
	logic signed [W-1:0] rate_q;
	logic signed [W-1:0] t_q;
	logic signed [W-1:0] inner_q;
	logic signed [W-1:0] s_q;
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] k0_q;
	logic signed [W-1:0] k1_q;
	logic signed [W-1:0] p00_q;
	logic signed [W-1:0] p01_q;
	logic signed [OUT_W-1:0] fa_q;
	logic signed [OUT_W-1:0] ur_q;
	logic signed [OUT_W-1:0] be_q;

	logic signed [W-1:0] qa_w;
	logic signed [W-1:0] qb_w;
	logic signed [W-1:0] rm_w;
	logic signed [W-1:0] ma_w;
	logic signed [W-1:0] mr_w;
	logic signed [W-1:0] dt_w;
	logic signed [W-1:0] mul_a;
	logic signed [W-1:0] mul_b;
	logic signed [W-1:0] mul_res;
	logic signed [W-1:0] k0_res;
	logic signed [W-1:0] k1_res;
	logic                mul_busy;
	logic                mul_done;
	logic                div_busy;
	logic                div_done;

	function automatic logic signed [EW-1:0] ex(input logic signed [W-1:0] v);
		return {{2{v[W-1]}}, v};
	endfunction

	function automatic logic signed [W-1:0] sat_e(input logic signed [EW-1:0] v);
		if (v > WMAX_E) return WMAX_E[W-1:0];
		if (v < WMIN_E) return WMIN_E[W-1:0];
		return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] sat_in(input logic signed [XI-1:0] v);
		if (v > WMAX_X) return WMAX_X[W-1:0];
		if (v < WMIN_X) return WMIN_X[W-1:0];
		return v[W-1:0];
	endfunction

	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [W-1:0] v);
		logic signed [XI-1:0] vx;
		vx = {{(XI - W){v[W-1]}}, v};
		if (vx > OMAX_X) return OMAX_X[OUT_W-1:0];
		if (vx < OMIN_X) return OMIN_X[OUT_W-1:0];
		return vx[OUT_W-1:0];
	endfunction

	assign qa_w = sat_in({{(XI - CFG_W){1'b0}}, qa_q});
	assign qb_w = sat_in({{(XI - CFG_W){1'b0}}, qb_q});
	assign rm_w = sat_in({{(XI - CFG_W){1'b0}}, rm_q});
	assign ma_w = sat_in({{(XI - ANGLE_W){measured_angle[ANGLE_W-1]}}, measured_angle});
	assign mr_w = sat_in({{(XI - RATE_W){measured_rate[RATE_W-1]}}, measured_rate});
	assign dt_w = sat_in({{(XI - DT_W){1'b0}}, time_step});

	always_comb begin
		unique case (cmd.mul_op)
			MOP_ANGLE_PRED: begin
				mul_a = dt_q;
				mul_b = rate_q;
			end
			MOP_T: begin
				mul_a = dt_q;
				mul_b = p_q[3];
			end
			MOP_P0_PRED: begin
				mul_a = dt_q;
				mul_b = inner_q;
			end
			MOP_P3_PRED: begin
				mul_a = qb_w;
				mul_b = dt_q;
			end
			MOP_ANGLE_CORR: begin
				mul_a = k0_q;
				mul_b = y_q;
			end
			MOP_BIAS_CORR: begin
				mul_a = k1_q;
				mul_b = y_q;
			end
			MOP_P0_CORR: begin
				mul_a = k0_q;
				mul_b = p00_q;
			end
			MOP_P1_CORR: begin
				mul_a = k0_q;
				mul_b = p01_q;
			end
			MOP_P2_CORR: begin
				mul_a = k1_q;
				mul_b = p00_q;
			end
			MOP_P3_CORR: begin
				mul_a = k1_q;
				mul_b = p01_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	kabf_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.res    (mul_res)
	);

	kabf_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.n0     (p_q[0]),
		.n1     (p_q[2]),
		.d      (s_q),
		.busy   (div_busy),
		.done   (div_done),
		.q0     (k0_res),
		.q1     (k1_res)
	);

	// filter state and noise registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q   <= ANGLE_NOISE_RST;
			qb_q   <= BIAS_NOISE_RST;
			rm_q   <= MEAS_NOISE_RST;
			ang_q  <= '0;
			bias_q <= '0;
			for (int i = 0; i < 4; i++) begin
				p_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ANGLE_NOISE: qa_q <= cfg_wdata;
					CFG_BIAS_NOISE:  qb_q <= cfg_wdata;
					CFG_MEAS_NOISE:  rm_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.step_inner) begin
				p_q[1] <= sat_e(ex(p_q[1]) - ex(t_q));
				p_q[2] <= sat_e(ex(p_q[2]) - ex(t_q));
			end
			if (cmd.mul_wb) begin
				unique case (cmd.mul_op)
					MOP_ANGLE_PRED: ang_q  <= sat_e(ex(ang_q) + ex(mul_res));
					MOP_P0_PRED:    p_q[0] <= sat_e(ex(p_q[0]) + ex(mul_res));
					MOP_P3_PRED:    p_q[3] <= sat_e(ex(p_q[3]) + ex(mul_res));
					MOP_ANGLE_CORR: ang_q  <= sat_e(ex(ang_q) + ex(mul_res));
					MOP_BIAS_CORR:  bias_q <= sat_e(ex(bias_q) + ex(mul_res));
					MOP_P0_CORR:    p_q[0] <= sat_e(ex(p_q[0]) - ex(mul_res));
					MOP_P1_CORR:    p_q[1] <= sat_e(ex(p_q[1]) - ex(mul_res));
					MOP_P2_CORR:    p_q[2] <= sat_e(ex(p_q[2]) - ex(mul_res));
					MOP_P3_CORR:    p_q[3] <= sat_e(ex(p_q[3]) - ex(mul_res));
					default: ;
				endcase
			end
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ma_q   <= ma_w;
			dt_q   <= dt_w;
			rate_q <= sat_e(ex(mr_w) - ex(bias_q));
		end
		if (cmd.mul_wb && cmd.mul_op == MOP_T) begin
			t_q <= mul_res;
		end
		if (cmd.step_inner) begin
			inner_q <= sat_e(ex(t_q) - ex(p_q[1]) - ex(p_q[2]) + ex(qa_w));
		end
		if (cmd.step_gain) begin
			s_q   <= sat_e(ex(p_q[0]) + ex(rm_w));
			y_q   <= sat_e(ex(ma_q) - ex(ang_q));
			p00_q <= p_q[0];
			p01_q <= p_q[1];
		end
		if (cmd.div_wb) begin
			k0_q <= k0_res;
			k1_q <= k1_res;
		end
		if (cmd.out_load) begin
			fa_q <= sat32(ang_q);
			ur_q <= sat32(rate_q);
			be_q <= sat32(bias_q);
		end
	end

	assign status.mul_busy = mul_busy;
	assign status.mul_done = mul_done;
	assign status.div_busy = div_busy;
	assign status.div_done = div_done;

	assign filtered_angle = fa_q;
	assign unbiased_rate  = ur_q;
	assign bias_estimate  = be_q;

endmodule

@@ hw/rtl/kabf_ctrl.sv @@
// ----------------------------------------------------------------------------
// kabf_ctrl
// Sequencer of one filter step: load, ten multiplies, covariance and gain
// steps, the gain division and the hand-off into the output register.
// ----------------------------------------------------------------------------
module kabf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  kabf_pkg::dp_status_t status,
	output kabf_pkg::ctrl_cmd_t  cmd
);
	import kabf_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	mul_op_t     mop_q;
	mul_op_t     mop_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mop_q       <= MOP_ANGLE_PRED;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mop_q   <= mop_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		mop_d      = mop_q;
		cmd        = '0;
		cmd.mul_op = mop_q;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					mop_d    = MOP_ANGLE_PRED;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_d       = ST_MUL_WAIT;
			end
			ST_MUL_WAIT: begin
				if (status.mul_done) begin
					cmd.mul_wb = 1'b1;
					state_d    = ST_MUL;
					unique case (mop_q)
						MOP_ANGLE_PRED: mop_d = MOP_T;
						MOP_T:          state_d = ST_INNER;
						MOP_P0_PRED:    mop_d = MOP_P3_PRED;
						MOP_P3_PRED:    state_d = ST_GAIN;
						MOP_ANGLE_CORR: mop_d = MOP_BIAS_CORR;
						MOP_BIAS_CORR:  mop_d = MOP_P0_CORR;
						MOP_P0_CORR:    mop_d = MOP_P1_CORR;
						MOP_P1_CORR:    mop_d = MOP_P2_CORR;
						MOP_P2_CORR:    mop_d = MOP_P3_CORR;
						MOP_P3_CORR:    state_d = ST_OUT;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_INNER: begin
				cmd.step_inner = 1'b1;
				mop_d          = MOP_P0_PRED;
				state_d        = ST_MUL;
			end
			ST_GAIN: begin
				cmd.step_gain = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_wb = 1'b1;
					mop_d      = MOP_ANGLE_CORR;
					state_d    = ST_MUL;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !status.mul_busy && !status.div_busy)
		else $error("arithmetic unit busy while idle");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("output word raised outside the output step");
`endif

endmodule

@@ hw/rtl/kalman_angle_bias_filter.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state Kalman filter for tilt angle and gyro bias in fixed point.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per IMU sample (measured angle, gyro rate, time
// step). Output stream m_*: one word per sample (filtered angle, unbiased
// rate, bias estimate). Noise variances must be written by the user through
// cfg_* only while the block is idle; the block itself does not enforce this.
// Writes to an unknown index are ignored. Each sample runs through a
// sequencer that shares one digit-serial multiplier and one restoring
// divider. A new sample is accepted only after the previous one's output
// word is loaded. Of the time a sample takes, the divider, one quotient bit
// per cycle over WORD_WIDTH+24 bits, is the largest part, the ten multiplies
// most of the rest. s_tready is high only between samples. The output register
// holds a finished word while the next sample is accepted and processed;
// if the receiver still stalls when the next word is ready, the sequencer
// waits for it. Reset clears the angle, bias and covariance to zero, loads
// the default noise values and empties the output register.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter #(
	parameter int WORD_WIDTH = kabf_pkg::WORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// measured_angle [24:0], measured_rate [52:25], time_step [77:53]
	input  logic [kabf_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// filtered_angle [31:0], unbiased_rate [63:32], bias_estimate [95:64]
	output logic [kabf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input  logic                                cfg_we,
	input  logic [kabf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kabf_pkg::CFG_W-1:0]          cfg_wdata
);
	import kabf_pkg::*;

	ctrl_cmd_t            cmd;
	dp_status_t           status;
	logic signed [OUT_W-1:0] filtered_angle;
	logic signed [OUT_W-1:0] unbiased_rate;
	logic signed [OUT_W-1:0] bias_estimate;

	kabf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	kabf_datapath #(.W(WORD_WIDTH)) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.measured_angle (s_tdata[24:0]),
		.measured_rate  (s_tdata[52:25]),
		.time_step      (s_tdata[77:53]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.filtered_angle (filtered_angle),
		.unbiased_rate  (unbiased_rate),
		.bias_estimate  (bias_estimate)
	);

	assign m_tdata = {bias_estimate, unbiased_rate, filtered_angle};

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the angle and gyro bias Kalman filter. A short
// table of samples and noise writes covers the field extremes, zero noise
// and an ignored register index, then about 1150 random samples run over ten
// noise settings. Each output word is checked against the table's value or
// an in-bench fixed-point model, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;

	import kabf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
	localparam longint WMAX         = 64'sd2147483647;
	localparam longint WMIN         = -64'sd2147483648;
	localparam int     LATENCY      = 113;
	localparam int     IDLE_PAUSE   = 4;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     PHASES       = 10;
	localparam int     PHASE_ITEMS  = 115;
	localparam int     PRINT_LIMIT  = 200;

	typedef struct packed {
		logic [DT_W-1:0]    dt;
		logic [RATE_W-1:0]  rate;
		logic [ANGLE_W-1:0] angle;
	} imu_sample_t;

	typedef struct packed {
		logic [OUT_W-1:0] bias;
		logic [OUT_W-1:0] rate;
		logic [OUT_W-1:0] angle;
	} estimate_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		imu_sample_t        smp;
		bit                 typed;
		estimate_t          want;
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_W-1:0]   value;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_wdata = '0;

	// filter state as the block should hold it
	longint           est_angle = 0;
	longint           est_bias  = 0;
	longint           cov [4]   = '{0, 0, 0, 0};
	logic [CFG_W-1:0] noise_angle = ANGLE_NOISE_RST;
	logic [CFG_W-1:0] noise_bias  = BIAS_NOISE_RST;
	logic [CFG_W-1:0] noise_meas  = MEAS_NOISE_RST;

	estimate_t expected_estimates [$];
	plan_row_t directed_plan [$];
	int        mismatch_count = 0;
	bit        tx_burst = 1'b0;
	bit        rx_burst = 1'b0;

	kalman_angle_bias_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint clamp_word(longint v);
		if (v > WMAX)
			return WMAX;
		if (v < WMIN)
			return WMIN;
		return v;
	endfunction

	function automatic longint magnitude_limit(bit neg, longint unsigned mag);
		longint unsigned lim;
		lim = neg ? 64'd2147483648 : 64'd2147483647;
		if (mag > lim)
			mag = lim;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	// q8.24 product, rounded half away from zero
	function automatic longint fx_mul(longint a, longint b);
		bit neg;
		longint unsigned ua, ub;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		return magnitude_limit(neg, (ua * ub + 64'd8388608) >> FRAC_BITS);
	endfunction

	// q8.24 quotient, truncated toward zero, zero divisor gives zero
	function automatic longint fx_div(longint n, longint d);
		bit neg;
		longint unsigned un, ud;
		if (d == 0)
			return 0;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		return magnitude_limit(neg, (un << FRAC_BITS) / ud);
	endfunction

	function automatic estimate_t run_filter(imu_sample_t smp);
		longint ma, mr, dt, qa, qb, rm;
		longint rate, t, inner, s_var, k0, k1, y, p00, p01;
		estimate_t e;
		ma = longint'($signed(smp.angle));
		mr = longint'($signed(smp.rate));
		dt = longint'(smp.dt);
		qa = longint'(noise_angle);
		qb = longint'(noise_bias);
		rm = longint'(noise_meas);

		// predict
		rate = clamp_word(mr - est_bias);
		est_angle = clamp_word(est_angle + fx_mul(dt, rate));
		t = fx_mul(dt, cov[3]);
		inner = clamp_word(t - cov[1] - cov[2] + qa);
		cov[0] = clamp_word(cov[0] + fx_mul(dt, inner));
		cov[1] = clamp_word(cov[1] - t);
		cov[2] = clamp_word(cov[2] - t);
		cov[3] = clamp_word(cov[3] + fx_mul(qb, dt));

		// gains and innovation
		s_var = clamp_word(cov[0] + rm);
		k0 = fx_div(cov[0], s_var);
		k1 = fx_div(cov[2], s_var);
		y = clamp_word(ma - est_angle);

		// correct
		est_angle = clamp_word(est_angle + fx_mul(k0, y));
		est_bias = clamp_word(est_bias + fx_mul(k1, y));
		p00 = cov[0];
		p01 = cov[1];
		cov[0] = clamp_word(cov[0] - fx_mul(k0, p00));
		cov[1] = clamp_word(cov[1] - fx_mul(k0, p01));
		cov[2] = clamp_word(cov[2] - fx_mul(k1, p00));
		cov[3] = clamp_word(cov[3] - fx_mul(k1, p01));

		e.angle = est_angle[OUT_W-1:0];
		e.rate = rate[OUT_W-1:0];
		e.bias = est_bias[OUT_W-1:0];
		return e;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch %s: got %0d, want %0d", what, got, want);
		mismatch_count++;
	endtask

	task automatic check_word(estimate_t got);
		estimate_t want;
		if (expected_estimates.size() == 0) begin
			flag_mismatch("unexpected output word, angle", int'(got.angle), 0);
		end else begin
			want = expected_estimates.pop_front();
			if (got.angle !== want.angle)
				flag_mismatch("filtered_angle", int'(got.angle), int'(want.angle));
			if (got.rate !== want.rate)
				flag_mismatch("unbiased_rate", int'(got.rate), int'(want.rate));
			if (got.bias !== want.bias)
				flag_mismatch("bias_estimate", int'(got.bias), int'(want.bias));
		end
	endtask

	task automatic send_sample(imu_sample_t smp, bit typed, estimate_t want);
		int gap;
		estimate_t model;
		gap = tx_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model = run_filter(smp);
		expected_estimates.push_back(typed ? want : model);
	endtask

	task automatic await_idle();
		s_tvalid <= 1'b0;
		while (expected_estimates.size() != 0)
			@(posedge clk);
		repeat (IDLE_PAUSE) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		await_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_ANGLE_NOISE: noise_angle = val;
			CFG_BIAS_NOISE:  noise_bias = val;
			CFG_MEAS_NOISE:  noise_meas = val;
			default: ;
		endcase
	endtask

	task automatic plan_checked(int a, int r, int dt, int wa, int wr, int wb);
		plan_row_t row;
		row.kind = ROW_SAMPLE;
		row.smp.angle = ANGLE_W'(a);
		row.smp.rate = RATE_W'(r);
		row.smp.dt = DT_W'(dt);
		row.typed = 1'b1;
		row.want.angle = wa;
		row.want.rate = wr;
		row.want.bias = wb;
		row.index = '0;
		row.value = '0;
		directed_plan.push_back(row);
	endtask

	task automatic plan_sample(int a, int r, int dt);
		plan_checked(a, r, dt, 0, 0, 0);
		directed_plan[$].typed = 1'b0;
	endtask

	task automatic plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		plan_row_t row;
		row.kind = ROW_WRITE;
		row.smp = '0;
		row.typed = 1'b0;
		row.want = '0;
		row.index = idx;
		row.value = val;
		directed_plan.push_back(row);
	endtask

	function automatic imu_sample_t random_sample();
		imu_sample_t smp;
		if ($urandom_range(0, 9) == 0) begin
			smp.angle = ANGLE_W'($urandom());
			smp.rate = RATE_W'($urandom());
			smp.dt = DT_W'($urandom());
		end else begin
			smp.angle = ANGLE_W'(int'($urandom_range(0, 23592960)) - 11796480);
			if ($urandom_range(0, 4) == 0)
				smp.rate = RATE_W'(int'($urandom_range(0, 262144000)) - 131072000);
			else
				smp.rate = RATE_W'(int'($urandom_range(0, 32768000)) - 16384000);
			if ($urandom_range(0, 7) == 0)
				smp.dt = DT_W'($urandom_range(0, 16777216));
			else
				smp.dt = DT_W'($urandom_range(0, 4194304));
		end
		return smp;
	endfunction

	function automatic logic [CFG_W-1:0] random_noise();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return CFG_W'($urandom_range(0, 16777216));
			default: return CFG_W'($urandom_range(0, 32'h7FFFFFFF));
		endcase
	endfunction

	// sink: per word stall draw, then accept and check
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			check_word(m_tdata);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		estimate_t none;
		plan_row_t row;
		none = '0;

		// dt of zero from reset keeps angle, bias and covariance at zero
		plan_checked(0, 0, 0, 0, 0, 0);
		plan_checked(11796480, 131072000, 0, 0, 131072000, 0);
		plan_checked(-11796480, -131072000, 0, 0, -131072000, 0);
		plan_checked(-16777216, -134217728, 0, 0, -134217728, 0);
		plan_checked(16777215, 134217727, 0, 0, 134217727, 0);
		// zero noise: innovation variance zero, no correction
		plan_write(CFG_ANGLE_NOISE, '0);
		plan_write(CFG_BIAS_NOISE, '0);
		plan_write(CFG_MEAS_NOISE, '0);
		plan_checked(327680, 655360, 8388608, 327680, 655360, 0);
		plan_checked(0, -655360, 16777216, -327680, -655360, 0);
		// noise at full scale, inputs at and past the stated ranges
		plan_write(CFG_ANGLE_NOISE, '1);
		plan_write(CFG_BIAS_NOISE, '1);
		plan_write(CFG_MEAS_NOISE, '1);
		plan_sample(11796480, 131072000, 33554431);
		plan_sample(-11796480, -131072000, 16777216);
		plan_sample(-16777216, 134217727, 33554431);
		plan_write(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
		plan_write(CFG_BIAS_NOISE, BIAS_NOISE_RST);
		plan_write(CFG_MEAS_NOISE, MEAS_NOISE_RST);
		// unknown index must leave all noise values alone
		plan_write(CFG_NO_REG, '0);
		plan_sample(655360, 65536, 167772);
		plan_sample(1310720, 131072, 167772);
		plan_sample(1966080, -65536, 167772);
		plan_sample(-5898240, 16384000, 167772);
		plan_sample(5898240, -16384000, 1677722);
		plan_sample(0, 0, 167772);
		plan_sample(16777215, -134217728, 16777216);
		plan_sample(-16777216, 134217727, 1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			row = directed_plan[i];
			if (row.kind == ROW_WRITE)
				write_register(row.index, row.value);
			else
				send_sample(row.smp, row.typed, row.want);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					write_register(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
					write_register(CFG_BIAS_NOISE, BIAS_NOISE_RST);
					write_register(CFG_MEAS_NOISE, MEAS_NOISE_RST);
				end
				1: begin
					write_register(CFG_ANGLE_NOISE, '1);
					write_register(CFG_BIAS_NOISE, '1);
					write_register(CFG_MEAS_NOISE, '1);
				end
				2: begin
					write_register(CFG_ANGLE_NOISE, '0);
					write_register(CFG_BIAS_NOISE, '0);
					write_register(CFG_MEAS_NOISE, '0);
				end
				3: begin
					write_register(CFG_ANGLE_NOISE, ANGLE_NOISE_RST);
					write_register(CFG_BIAS_NOISE, BIAS_NOISE_RST);
					write_register(CFG_MEAS_NOISE, 31'd1);
				end
				default: begin
					write_register(CFG_ANGLE_NOISE, random_noise());
					write_register(CFG_BIAS_NOISE, random_noise());
					write_register(CFG_MEAS_NOISE, random_noise());
				end
			endcase
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 39) == 0)
					await_idle();
				send_sample(random_sample(), 1'b0, none);
			end
		end

		await_idle();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0 && expected_estimates.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
